// ===== rtl/buddy_block_allocator_macros.svh =====
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Implication checked in the cycle after the antecedent, sampled on clk and idle during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Invariant checked at every clock edge outside reset.
`define BBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

// ===== rtl/bba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  // Area geometry: largest managed area and smallest block, both log2 bytes.
  localparam int MAX_LOG_AREA  = 16;
  localparam int MIN_LOG_BLOCK = 6;

  // Free-map memory word geometry.
  localparam int FM_W  = 64;
  localparam int FM_WB = 6;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
  localparam logic [2:0] ST_NO_MEM     = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC  = 3'd4;

  typedef struct packed {
    logic             hit;
    logic [FM_WB-1:0] idx;
  } lowbit_t;

endpackage
`default_nettype wire

// ===== rtl/buddy_block_allocator.sv =====
// Buddy allocator over a power-of-two area of minimum-size blocks.
// Requests enter on the s_t* beat: s_tdata = {data_offset, alloc_size, mode},
// mode in the low bits. Every request gives exactly one result beat on m_t*:
// m_tdata = {bytes_free_now, block_log_size, result_offset, status}.
// The APB register log_area_size (address 0) sets the area size; a write
// restarts the clear and setup sequence as reset does.
// After reset or a register write the block sweeps all 2^(MAX_LOG_AREA-MIN_LOG_BLOCK)
// entries (1024) of its slot table, one entry a cycle, then carves out the
// header block before s_tready rises.
// One request is handled at a time. An allocation reads free-map words level
// by level towards the root until it finds a free node (up to 37 reads), marks
// it taken and splits once per level down to the asked size; a free reads
// the slot table, then looks at buddies and merges upward (one buddy more than
// the merges unless the merge reaches the root); a query reads only the slot
// table, and a rejected request goes straight to the result.
// Results sit in an output register: while the receiver stalls, the next
// request is still taken and worked on, and is held until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_macros.svh"
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // mode[1:0], alloc_size[17:2], data_offset[33:18]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], result_offset[18:3], block_log_size[23:19], bytes_free_now[40:24]
  output logic [47:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEVELS = MAX_LOG_AREA - MIN_LOG_BLOCK;
  localparam int NW     = LEVELS + 1;
  localparam int SW     = LEVELS;
  localparam int WAW    = NW - FM_WB;
  localparam int WORDS  = 1 << WAW;
  localparam int SLOTS  = 1 << SW;
  localparam int LVW    = $clog2(LEVELS + 1);
  localparam int AW     = MAX_LOG_AREA;
  localparam int BFW    = MAX_LOG_AREA + 1;
  localparam logic [4:0] MINL  = 5'(MIN_LOG_BLOCK);
  localparam logic [4:0] MAXL  = 5'(MAX_LOG_AREA);
  localparam logic [4:0] RSTL  = 5'(MAX_LOG_AREA < 16 ? MAX_LOG_AREA : 16);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_ROOT  = 13'b0000000000010,
    S_IDLE  = 13'b0000000000100,
    S_SRD   = 13'b0000000001000,
    S_SCHK  = 13'b0000000010000,
    S_MRD   = 13'b0000000100000,
    S_MWR   = 13'b0000001000000,
    S_SLOT  = 13'b0000010000000,
    S_FRD   = 13'b0000100000000,
    S_FCHK  = 13'b0001000000000,
    S_GRD   = 13'b0010000000000,
    S_GCHK  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;

  logic [FM_W-1:0] fmem [WORDS];
  logic [5:0]      smem [SLOTS];
  logic [FM_W-1:0] fm_rdata;
  logic [5:0]      sm_rdata;
  logic            fm_we;
  logic [WAW-1:0]  fm_waddr, fm_raddr;
  logic [FM_W-1:0] fm_wdata;
  logic            sm_we;
  logic [SW-1:0]   sm_waddr;
  logic [5:0]      sm_wdata;

  logic [4:0]      area_log;
  logic [SW-1:0]   cnt;
  logic [4:0]      lg;
  logic [LVW-1:0]  k, jl;
  logic [WAW-1:0]  w;
  logic [NW-1:0]   node, tnode;
  logic            tval, phase_free, setup, qry;
  logic [SW-1:0]   slot;
  logic [15:0]     offr;
  logic [2:0]      st;
  logic [15:0]     roff;
  logic [4:0]      rlog;
  logic [BFW-1:0]  bytes_free;

  function automatic logic [4:0] clog2_x(input logic [16:0] x);
    logic [4:0]  l;
    logic [16:0] y;
    l = '0;
    y = x - 17'd1;
    for (int i = 0; i < 17; i++) begin
      if (y[i]) l = 5'(i + 1);
    end
    if (x == '0) l = '0;
    return l;
  endfunction

  function automatic logic [WAW-1:0] first_w(input logic [LVW-1:0] j);
    return WAW'((NW'(1) << j) >> FM_WB);
  endfunction

  function automatic logic [WAW-1:0] last_w(input logic [LVW-1:0] j);
    return WAW'(((NW'(1) << (j + LVW'(1))) - NW'(1)) >> FM_WB);
  endfunction

  // Input decode.
  logic [1:0]  in_mode;
  logic [15:0] in_size, in_doff, in_off;
  logic [4:0]  req_raw, req_lg;
  logic        off_bad;
  assign in_mode = s_tdata[1:0];
  assign in_size = s_tdata[17:2];
  assign in_doff = s_tdata[33:18];
  assign in_off  = in_doff - 16'd4;
  assign req_raw = clog2_x(17'(in_size) + 17'd4);
  assign req_lg  = (req_raw < MINL) ? MINL : req_raw;
  assign off_bad = (in_doff < 16'd4) || (in_off == '0) ||
                   ((32'(in_off) >> area_log) != '0) ||
                   ((in_off & 16'((1 << MIN_LOG_BLOCK) - 1)) != '0);

  // Header block size for setup.
  logic [4:0] h_raw, h_min, hlog;
  assign h_raw = clog2_x((17'(area_log) + 17'd5 - 17'(MINL)) << 2);
  assign h_min = (h_raw < MINL) ? MINL : h_raw;
  assign hlog  = (h_min > area_log) ? area_log : h_min;

  // Level mask of the scanned word and its lowest free node.
  logic [FM_W-1:0] lvl_mask;
  lowbit_t         pe;
  always_comb begin
    for (int b = 0; b < FM_W; b++) begin
      lvl_mask[b] = ((NW'({w, FM_WB'(b)}) >> jl) == NW'(1));
    end
  end
  bba_lowbit u_lowbit (.vec(fm_rdata & lvl_mask), .res(pe));

  // Offset and slot of the node taken by an allocation.
  logic [NW-1:0] a_idx;
  logic [AW-1:0] a_off;
  logic [SW-1:0] a_slot;
  assign a_idx  = node & ((NW'(1) << k) - NW'(1));
  assign a_off  = AW'(a_idx) << lg;
  assign a_slot = SW'(a_off >> MIN_LOG_BLOCK);

  // Node of a block being freed, from its stored size.
  logic [LVW-1:0] f_k;
  logic [NW-1:0]  f_node, bud;
  assign f_k    = LVW'(area_log - sm_rdata[4:0]);
  assign f_node = (NW'(1) << f_k) | NW'(offr >> sm_rdata[4:0]);
  assign bud    = node ^ NW'(1);

  logic cfg_we;
  logic [4:0] cfg_v;
  assign cfg_we = psel && penable && pwrite && pready;
  assign cfg_v  = (pwdata[4:0] < MINL + 5'd1) ? MINL + 5'd1 :
                  (pwdata[4:0] > MAXL) ? MAXL : pwdata[4:0];
  assign pready = 1'b1;
  assign prdata = 32'(area_log);

  assign s_tready = (state == S_IDLE);

  // Memory port control.
  always_comb begin
    fm_we    = 1'b0;
    fm_waddr = '0;
    fm_wdata = '0;
    fm_raddr = w;
    sm_we    = 1'b0;
    sm_waddr = slot;
    sm_wdata = '0;
    case (state)
      S_CLEAR: begin
        fm_we    = ((cnt >> WAW) == '0);
        fm_waddr = WAW'(cnt);
        sm_we    = 1'b1;
        sm_waddr = cnt;
      end
      S_ROOT: begin
        fm_we    = 1'b1;
        fm_wdata = FM_W'(2);
      end
      S_MRD: fm_raddr = WAW'(tnode >> FM_WB);
      S_MWR: begin
        fm_we    = 1'b1;
        fm_waddr = WAW'(tnode >> FM_WB);
        fm_wdata = fm_rdata;
        fm_wdata[tnode[FM_WB-1:0]] = tval;
      end
      S_SLOT: begin
        sm_we    = 1'b1;
        sm_waddr = a_slot;
        sm_wdata = {1'b1, lg};
      end
      S_FCHK: begin
        sm_we    = sm_rdata[5] && !qry;
        sm_wdata = {1'b0, sm_rdata[4:0]};
      end
      S_GRD: fm_raddr = WAW'(bud >> FM_WB);
      S_GCHK: begin
        fm_we    = fm_rdata[bud[FM_WB-1:0]];
        fm_waddr = WAW'(bud >> FM_WB);
        fm_wdata = fm_rdata;
        fm_wdata[bud[FM_WB-1:0]] = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fmem[fm_waddr] <= fm_wdata;
    fm_rdata <= fmem[fm_raddr];
    if (sm_we) smem[sm_waddr] <= sm_wdata;
    sm_rdata <= smem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cnt        <= '0;
      area_log   <= RSTL;
      bytes_free <= '0;
      m_tvalid   <= 1'b0;
      setup      <= 1'b0;
    end else begin
      // The done state reloads the output register itself.
      if (m_tready && state != S_DONE) m_tvalid <= 1'b0;
      if (cfg_we) begin
        area_log   <= cfg_v;
        cnt        <= '0;
        bytes_free <= '0;
        state      <= S_CLEAR;
      end else begin
        case (state)
          S_CLEAR: begin
            cnt <= cnt + SW'(1);
            if (cnt == SW'(SLOTS - 1)) state <= S_ROOT;
          end
          S_ROOT: begin
            setup      <= 1'b1;
            phase_free <= 1'b0;
            lg         <= hlog;
            k          <= LVW'(area_log - hlog);
            jl         <= LVW'(area_log - hlog);
            w          <= first_w(LVW'(area_log - hlog));
            state      <= S_SRD;
          end
          S_IDLE: begin
            if (s_tvalid) begin
              st    <= ST_OK;
              roff  <= '0;
              rlog  <= '0;
              setup <= 1'b0;
              qry   <= (in_mode == MODE_QUERY);
              state <= S_DONE;
              if (in_mode == MODE_ALLOC) begin
                if (in_size == '0 || req_lg >= area_log) begin
                  st <= ST_BAD_SIZE;
                end else begin
                  phase_free <= 1'b0;
                  lg    <= req_lg;
                  k     <= LVW'(area_log - req_lg);
                  jl    <= LVW'(area_log - req_lg);
                  w     <= first_w(LVW'(area_log - req_lg));
                  state <= S_SRD;
                end
              end else if (in_mode == MODE_FREE || in_mode == MODE_QUERY) begin
                if (off_bad) begin
                  st <= ST_BAD_OFFSET;
                end else begin
                  offr  <= in_off;
                  slot  <= SW'(in_off >> MIN_LOG_BLOCK);
                  state <= S_FRD;
                end
              end
            end
          end
          S_SRD: state <= S_SCHK;
          S_SCHK: begin
            if (pe.hit) begin
              node  <= {w, pe.idx};
              tnode <= {w, pe.idx};
              tval  <= 1'b0;
              state <= S_MRD;
            end else if (w != last_w(jl)) begin
              w     <= w + WAW'(1);
              state <= S_SRD;
            end else if (jl == '0) begin
              st    <= ST_NO_MEM;
              state <= S_DONE;
            end else begin
              jl    <= jl - LVW'(1);
              w     <= first_w(jl - LVW'(1));
              state <= S_SRD;
            end
          end
          S_MRD: state <= S_MWR;
          S_MWR: begin
            if (phase_free) begin
              bytes_free <= bytes_free + (BFW'(1) << lg);
              rlog       <= lg;
              state      <= S_DONE;
            end else if (jl != k) begin
              // Split: descend to the lower half, the upper half becomes free.
              node  <= node << 1;
              tnode <= (node << 1) | NW'(1);
              tval  <= 1'b1;
              jl    <= jl + LVW'(1);
              state <= S_MRD;
            end else begin
              state <= S_SLOT;
            end
          end
          S_SLOT: begin
            if (setup) begin
              bytes_free <= (BFW'(1) << area_log) - (BFW'(1) << lg);
              state      <= S_IDLE;
            end else begin
              bytes_free <= bytes_free - (BFW'(1) << lg);
              roff       <= 16'(a_off + AW'(4));
              rlog       <= lg;
              state      <= S_DONE;
            end
          end
          S_FRD: state <= S_FCHK;
          S_FCHK: begin
            if (!sm_rdata[5]) begin
              st    <= ST_NOT_ALLOC;
              state <= S_DONE;
            end else if (qry) begin
              rlog  <= sm_rdata[4:0];
              state <= S_DONE;
            end else begin
              lg         <= sm_rdata[4:0];
              k          <= f_k;
              node       <= f_node;
              tnode      <= f_node;
              tval       <= 1'b1;
              phase_free <= 1'b1;
              state      <= (f_k == '0) ? S_MRD : S_GRD;
            end
          end
          S_GRD: state <= S_GCHK;
          S_GCHK: begin
            if (fm_rdata[bud[FM_WB-1:0]]) begin
              // Buddy is free: it is absorbed and the merge moves one level up.
              node  <= node >> 1;
              tnode <= node >> 1;
              k     <= k - LVW'(1);
              state <= (k == LVW'(1)) ? S_MRD : S_GRD;
            end else begin
              state <= S_MRD;
            end
          end
          S_DONE: begin
            if (!m_tvalid || m_tready) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {7'b0, 17'(bytes_free), rlog, roff, st};
              state    <= S_IDLE;
            end
          end
          default: state <= S_CLEAR;
        endcase
      end
    end
  end

  `BBA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")
  `BBA_ASSERT_NEXT(a_cfg_restart, cfg_we, state == S_CLEAR, "register write did not restart")
  `BBA_ASSERT_ALWAYS(a_free_bound, bytes_free <= (BFW'(1) << area_log), "free bytes exceed area")

endmodule
`default_nettype wire

// ===== rtl/bba_lowbit.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bba_lowbit
  import bba_pkg::*;
(
  input  logic [FM_W-1:0] vec,
  output lowbit_t         res
);

  // Lowest set bit wins, which is the lowest offset within a tree level.
  always_comb begin
    res = '0;
    for (int i = FM_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.hit = 1'b1;
        res.idx = FM_WB'(i);
      end
    end
  end

endmodule
`default_nettype wire

// ===== dv/buddy_block_allocator_tb.sv =====
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
  import bba_pkg::*;

  localparam int MAX_LOG = 16;
  localparam int MIN_LOG = 6;
  localparam int NODES = 2 << (MAX_LOG - MIN_LOG);
  localparam int SLOTS = 1 << (MAX_LOG - MIN_LOG);
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] offset;
    logic [4:0]  log_size;
    logic [16:0] free_bytes;
  } alloc_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  // mode[1:0], alloc_size[17:2], data_offset[33:18]
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // status[2:0], result_offset[18:3], block_log_size[23:19], bytes_free_now[40:24]
  logic [47:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  buddy_block_allocator u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow allocator state.
  int          area_log;
  bit          node_free [NODES];
  logic [4:0]  slot_log [SLOTS];
  bit          slot_used [SLOTS];
  int          free_total;

  alloc_result_t pending_results[$];
  int          live_blocks[$];
  int          errors = 0;
  int          items_sent = 0;
  int          beats_checked = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;

  function automatic int ceil_log2(int x);
    int l = 0;
    while (l < 31 && (1 << l) < x) l++;
    return l;
  endfunction

  function automatic int block_log_for(int payload);
    int l = ceil_log2(payload + 4);
    return (l < MIN_LOG) ? MIN_LOG : l;
  endfunction

  function automatic int carve_block(int lg);
    int depth = area_log - lg;
    int j = depth;
    int node = 0;
    int off;
    bit found = 0;
    while (1) begin
      for (int n = 1 << j; n < (2 << j); n++) begin
        if (node_free[n]) begin
          node = n;
          found = 1;
          break;
        end
      end
      if (found || j == 0) break;
      j--;
    end
    if (!found) return -1;
    node_free[node] = 0;
    while (j < depth) begin
      node = node << 1;
      node_free[node + 1] = 1;
      j++;
    end
    off = (node - (1 << depth)) << lg;
    slot_used[off >> MIN_LOG] = 1;
    slot_log[off >> MIN_LOG] = 5'(lg);
    return off;
  endfunction

  function automatic void init_area(int raw);
    int hlog;
    int unused_off;
    area_log = raw & 31;
    if (area_log < MIN_LOG + 1) area_log = MIN_LOG + 1;
    if (area_log > MAX_LOG) area_log = MAX_LOG;
    hlog = block_log_for(16 + 4 * (area_log - MIN_LOG + 1) - 4);
    if (hlog > area_log) hlog = area_log;
    foreach (node_free[i]) node_free[i] = 0;
    foreach (slot_used[i]) begin
      slot_used[i] = 0;
      slot_log[i] = '0;
    end
    node_free[1] = 1;
    unused_off = carve_block(hlog);
    free_total = (1 << area_log) - (1 << hlog);
    live_blocks.delete();
  endfunction

  function automatic alloc_result_t predict_request(logic [1:0] mode, int size, int doff);
    alloc_result_t r;
    int lg;
    int off;
    int depth;
    int node;
    r.status = ST_OK;
    r.offset = '0;
    r.log_size = '0;
    if (mode == MODE_ALLOC) begin
      lg = block_log_for(size);
      if (size == 0 || lg >= area_log) begin
        r.status = ST_BAD_SIZE;
      end else begin
        off = carve_block(lg);
        if (off < 0) begin
          r.status = ST_NO_MEM;
        end else begin
          free_total -= 1 << lg;
          r.offset = 16'(off + 4);
          r.log_size = 5'(lg);
          live_blocks.push_back(off + 4);
        end
      end
    end else if (mode == MODE_FREE || mode == MODE_QUERY) begin
      off = doff - 4;
      if (doff < 4 || off == 0 || off >= (1 << area_log) ||
          (off & ((1 << MIN_LOG) - 1)) != 0) begin
        r.status = ST_BAD_OFFSET;
      end else if (!slot_used[off >> MIN_LOG]) begin
        r.status = ST_NOT_ALLOC;
      end else begin
        lg = slot_log[off >> MIN_LOG];
        r.log_size = 5'(lg);
        if (mode == MODE_FREE) begin
          depth = area_log - lg;
          node = (1 << depth) + (off >> lg);
          slot_used[off >> MIN_LOG] = 0;
          while (depth > 0 && node_free[node ^ 1]) begin
            node_free[node ^ 1] = 0;
            node = node >> 1;
            depth--;
          end
          node_free[node] = 1;
          free_total += 1 << lg;
          foreach (live_blocks[i]) begin
            if (live_blocks[i] == doff) begin
              live_blocks.delete(i);
              break;
            end
          end
        end
      end
    end
    r.free_bytes = 17'(free_total);
    return r;
  endfunction

  // Valid stays high between back-to-back requests; the handshake is judged
  // from tready sampled mid-cycle.
  task automatic send_request(logic [1:0] mode, int size, int doff);
    logic ready_seen;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, 16'(doff), 16'(size), mode};
    do begin
      @(negedge clk);
      ready_seen = s_tready;
      @(posedge clk);
    end while (!ready_seen);
    pending_results.push_back(predict_request(mode, size, doff));
    items_sent++;
  endtask

  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_area_log(logic [31:0] value);
    wait_results_done();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    init_area(int'(value));
  endtask

  task automatic send_random_request();
    int pick = $urandom_range(99);
    int size;
    if (pick < 45) begin
      case ($urandom_range(9))
        0: size = $urandom_range(65535);
        1, 2: size = $urandom_range(1, 1 << (area_log - 1));
        default: size = $urandom_range(1, 300);
      endcase
      send_request(MODE_ALLOC, size, $urandom_range(65535));
    end else if (pick < 90 && live_blocks.size() != 0) begin
      send_request((pick < 78) ? MODE_FREE : MODE_QUERY, $urandom_range(65535),
                   live_blocks[$urandom_range(live_blocks.size() - 1)]);
    end else if (pick < 95) begin
      send_request(2'($urandom_range(1, 2)), $urandom_range(65535),
                   4 + 64 * $urandom_range((1 << (area_log - MIN_LOG)) - 1));
    end else begin
      send_request(2'($urandom_range(3)), $urandom_range(65535), $urandom_range(65535));
    end
  endtask

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  // Receiver: random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (hold_len > 0) begin
      m_tready <= 1'b0;
      hold_len <= hold_len - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // A result beat is judged mid-cycle, before the edge that accepts it.
  always @(negedge clk) begin
    alloc_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_tdata[2:0]);
        check_field("result_offset", want.offset, m_tdata[18:3]);
        check_field("block_log_size", want.log_size, m_tdata[23:19]);
        check_field("bytes_free_now", want.free_bytes, m_tdata[40:24]);
      end
    end
  end

  task automatic test_directed();
    int big_off;
    init_area(16);
    send_request(MODE_ALLOC, 0, 0);
    send_request(MODE_ALLOC, 1, 0);
    send_request(MODE_ALLOC, 60, 0);
    send_request(MODE_ALLOC, 61, 0);
    send_request(MODE_ALLOC, 65535, 0);
    send_request(MODE_ALLOC, 32764, 0);
    send_request(MODE_ALLOC, 32764, 0);
    big_off = live_blocks[live_blocks.size() - 1];
    send_request(MODE_QUERY, 0, big_off);
    send_request(MODE_FREE, 0, 0);
    send_request(MODE_FREE, 0, 3);
    send_request(MODE_FREE, 0, 4);
    send_request(MODE_QUERY, 0, 4);
    send_request(MODE_FREE, 0, 69);
    send_request(MODE_FREE, 0, 65535);
    send_request(MODE_FREE, 0, 4 + 64 * 500);
    send_request(MODE_FREE, 0, big_off);
    send_request(MODE_FREE, 0, big_off);
    send_request(MODE_UNUSED, 65535, 65535);
    while (live_blocks.size() != 0) send_request(MODE_FREE, 0, live_blocks[0]);
  endtask

  task automatic test_area_extremes();
    // Out-of-range values are clamped; the smallest area has room for one block beside the header.
    write_area_log(32'hFFFF_FFE0);
    send_request(MODE_ALLOC, 1, 0);
    send_request(MODE_ALLOC, 1, 0);
    send_request(MODE_ALLOC, 60, 0);
    send_request(MODE_FREE, 0, 132);
    send_request(MODE_QUERY, 0, 68);
    send_request(MODE_FREE, 0, 68);
    write_area_log(32'h0000_001F);
    send_request(MODE_ALLOC, 32000, 0);
    write_area_log(32'h5A5A_5A48);
    send_request(MODE_ALLOC, 100, 0);
    send_request(MODE_FREE, 0, 260);
  endtask

  task automatic test_random_mix(int area, int count);
    int pairs[4][2] = '{'{0, 0}, '{63, 0}, '{0, 63}, '{37, 37}};
    write_area_log(area);
    for (int p = 0; p < 4; p++) begin
      idle_pct = pairs[p][0];
      stall_pct = pairs[p][1];
      repeat (count / 4) send_random_request();
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_area_log(12);
    hold_len = 400;
    repeat (24) send_random_request();
    // Sender waits here for every outstanding result.
    wait_results_done();
    repeat (16) send_random_request();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_area_extremes();
    test_random_mix(16, 460);
    test_random_mix(9, 200);
    test_random_mix(12, 300);
    test_random_mix(8, 200);
    test_backpressure();
    wait_results_done();
    repeat (200) @(posedge clk);
    $display("Sent %0d requests over areas of 2^7 to 2^16 bytes; checked %0d result beats.",
             items_sent, beats_checked);
    $display("Covered allocate, free, query, bad requests, clamped sizes and long stalls.");
    if (errors == 0) begin
      $display("buddy_block_allocator_tb passed");
    end else begin
      $display("buddy_block_allocator_tb failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("buddy_block_allocator_tb failed");
    $finish;
  end

endmodule
